/* design/wfl_pkg.sv */
// shared types, constants and codes for the wave flux limiter
// no dependencies; imported by every module of the block
package wfl_pkg;

    localparam int LANES              = 5;
    localparam int MAX_COMPONENTS_DEF = 5;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int WORD_W             = 32;
    localparam int FACTOR_W           = 18;
    localparam int FACTOR_MAX         = 262143;
    localparam int DOT_W              = 64;
    localparam int QUO_W              = 31;
    localparam int CNT_W              = 3;
    localparam int IN_W               = 192;
    localparam int OUT_W              = 184;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_NONE     = 3'd0;
    localparam mode_t MODE_MINMOD   = 3'd1;
    localparam mode_t MODE_SUPERBEE = 3'd2;
    localparam mode_t MODE_VANLEER  = 3'd3;
    localparam mode_t MODE_MC       = 3'd4;
    localparam mode_t MODE_BW       = 3'd5;
    localparam mode_t MODE_ZERO     = 3'd6;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COMPS = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;

    // one inner wave ready for limiting
    typedef struct packed {
        logic [LANES-1:0][WORD_W-1:0] wave;
        logic signed [DOT_W-1:0]      sel_dot;
        logic signed [DOT_W-1:0]      norm;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* design/wfl_queue.sv */
// two-entry job queue between the front and the back
// depends on wfl_pkg
module wfl_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  wfl_pkg::job_t      push_job,
    input  logic               pop,
    output wfl_pkg::job_t      head_job,
    output wfl_pkg::q_status_t status
);
    import wfl_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule

/* design/wfl_front.sv */
// front end: slice tracking and dot products, one lane per cycle
// depends on wfl_pkg; feeds wfl_queue
module wfl_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wfl_pkg::LANES-1:0][wfl_pkg::WORD_W-1:0] in_wave,
    input  logic [wfl_pkg::WORD_W-1:0]    in_speed,
    input  logic                          in_start,
    input  logic                          in_end,
    input  logic [wfl_pkg::CNT_W-1:0]     n_active,
    input  wfl_pkg::q_status_t            q_stat,
    output logic                          push,
    output wfl_pkg::job_t                 push_job
);
    import wfl_pkg::*;

    localparam int ACC_W = DOT_W + $clog2(LANES) + 1;
    localparam int PRD_W = 2 * WORD_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MAC  = 3'b010,
        F_FIN  = 3'b100
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [LANES-1:0][WORD_W-1:0] held_reg, x_reg;
    logic signed [WORD_W-1:0]     speed_reg, x_speed_reg;
    logic signed [DOT_W-1:0]      left_dot_reg;
    logic                         inner_reg, in_slice_reg, x_end_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic signed [PRD_W-1:0]      prod_d_reg, prod_n_reg;
    logic signed [ACC_W-1:0]      acc_d_reg, acc_n_reg;
    logic signed [DOT_W-1:0]      dot_r, norm;
    logic                         accept;

    function automatic logic signed [DOT_W-1:0] sat_dot(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi, lo;
        begin
            hi = ACC_W'({1'b0, {(DOT_W-1){1'b1}}});
            lo = -hi - ACC_W'(1);
            if (v > hi)      sat_dot = {1'b0, {(DOT_W-1){1'b1}}};
            else if (v < lo) sat_dot = {1'b1, {(DOT_W-1){1'b0}}};
            else             sat_dot = v[DOT_W-1:0];
        end
    endfunction

    assign in_ready = (state_reg == F_IDLE);
    assign accept   = in_valid && in_ready;
    assign dot_r    = sat_dot(acc_d_reg);
    assign norm     = sat_dot(acc_n_reg);
    assign push     = (state_reg == F_FIN) && inner_reg && !q_stat.full;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            push_job.wave[j] = (j < int'(n_active)) ? held_reg[j] : '0;
        end
        push_job.sel_dot = (speed_reg > 0) ? left_dot_reg : dot_r;
        push_job.norm    = norm;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (accept && !in_start && in_slice_reg) state_next = F_MAC;
            F_MAC:  if (cnt_reg == n_active) state_next = F_FIN;
            F_FIN:  if (!(inner_reg && q_stat.full)) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // payload and products
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && accept && !in_start && in_slice_reg) begin
            x_reg       <= in_wave;
            x_speed_reg <= in_speed;
            x_end_reg   <= in_end;
        end
        if (state_reg == F_MAC && cnt_reg < n_active) begin
            prod_d_reg <= $signed(held_reg[cnt_reg]) * $signed(x_reg[cnt_reg]);
            prod_n_reg <= $signed(held_reg[cnt_reg]) * $signed(held_reg[cnt_reg]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            held_reg     <= '0;
            speed_reg    <= '0;
            left_dot_reg <= '0;
            inner_reg    <= 1'b0;
            in_slice_reg <= 1'b0;
            cnt_reg      <= '0;
            acc_d_reg    <= '0;
            acc_n_reg    <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                F_IDLE: begin
                    if (accept && in_start) begin
                        held_reg     <= in_wave;
                        speed_reg    <= in_speed;
                        left_dot_reg <= '0;
                        inner_reg    <= 1'b0;
                        in_slice_reg <= !in_end;
                    end
                    cnt_reg   <= '0;
                    acc_d_reg <= '0;
                    acc_n_reg <= '0;
                end
                F_MAC: begin
                    if (cnt_reg != '0) begin
                        acc_d_reg <= acc_d_reg + ACC_W'(prod_d_reg);
                        acc_n_reg <= acc_n_reg + ACC_W'(prod_n_reg);
                    end
                    if (cnt_reg != n_active) cnt_reg <= cnt_reg + CNT_W'(1);
                end
                F_FIN: begin
                    if (!(inner_reg && q_stat.full)) begin
                        left_dot_reg <= dot_r;
                        held_reg     <= x_reg;
                        speed_reg    <= x_speed_reg;
                        inner_reg    <= !x_end_reg;
                        in_slice_reg <= !x_end_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* design/wfl_div.sv */
// restoring divider, one quotient bit per cycle
// depends on wfl_pkg; used by wfl_back for the ratio and the van leer factor
module wfl_div #(
    parameter int NUM_W = wfl_pkg::DOT_W + wfl_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [NUM_W-1:0]               num,
    input  logic [wfl_pkg::DOT_W-1:0]      den,
    output logic                           done,
    output logic [wfl_pkg::QUO_W-1:0]      quo
);
    import wfl_pkg::*;

    localparam int CW = $clog2(QUO_W + 1);

    logic [DOT_W-1:0] rem_reg, den_reg;
    logic [QUO_W-1:0] low_reg, quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [DOT_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DOT_W'(num >> QUO_W);
            low_reg <= num[QUO_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? DOT_W'(trial - {1'b0, den_reg}) : trial[DOT_W-1:0];
            low_reg <= low_reg << 1;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QUO_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* design/wfl_back.sv */
// back end: ratio, limiter factor, scaling and output register
// depends on wfl_pkg and wfl_div; drains wfl_queue
module wfl_back #(
    parameter int FRAC_BITS = wfl_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wfl_pkg::q_status_t           q_stat,
    input  wfl_pkg::job_t                head_job,
    output logic                         pop,
    input  wfl_pkg::mode_t               mode,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [wfl_pkg::LANES-1:0][wfl_pkg::WORD_W-1:0] out_lim,
    output logic [wfl_pkg::FACTOR_W-1:0] out_factor,
    output logic                         out_scaled
);
    import wfl_pkg::*;

    localparam int NUM_W = DOT_W + FRAC_BITS;
    localparam int CMP_W = DOT_W + QUO_W - FRAC_BITS;
    localparam int RW    = WORD_W + 1;
    localparam int TW    = WORD_W + 4;
    localparam int PW    = WORD_W + FACTOR_W + 1;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_DIV_R = 5'b00010,
        B_LIM   = 5'b00100,
        B_DIV_V = 5'b01000,
        B_SCALE = 5'b10000
    } bstate_t;

    bstate_t state_reg, state_next;

    logic [LANES-1:0][WORD_W-1:0] wave_reg;
    logic                         neg_reg, scaled_reg, out_valid_reg;
    logic signed [RW-1:0]         r_reg;
    logic [FACTOR_W-1:0]          f_reg;
    logic [LANES-1:0][WORD_W-1:0] lim_reg;
    logic [FACTOR_W-1:0]          factor_reg;
    logic                         out_scaled_reg;

    logic [DOT_W-1:0] mag_a;
    logic             norm_pos, ratio_sat, vl_go, out_load;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [DOT_W-1:0] div_den;
    logic [QUO_W-1:0] div_quo;

    function automatic logic signed [TW-1:0] smin(input logic signed [TW-1:0] a, b);
        smin = (a < b) ? a : b;
    endfunction

    function automatic logic signed [TW-1:0] smax(input logic signed [TW-1:0] a, b);
        smax = (a > b) ? a : b;
    endfunction

    function automatic logic [FACTOR_W-1:0] clamp_f(input logic signed [TW-1:0] t);
        if (t < 0)                      clamp_f = '0;
        else if (t > TW'(FACTOR_MAX))   clamp_f = FACTOR_W'(FACTOR_MAX);
        else                            clamp_f = t[FACTOR_W-1:0];
    endfunction

    function automatic logic [FACTOR_W-1:0] theta(input mode_t m,
                                                  input logic signed [RW-1:0] r);
        logic signed [TW-1:0] one, two, rr, t;
        begin
            one = '0;
            one[FRAC_BITS] = 1'b1;
            two = one <<< 1;
            rr  = TW'(r);
            unique case (m)
                MODE_NONE:     t = one;
                MODE_MINMOD:   t = smax('0, smin(one, rr));
                MODE_SUPERBEE: t = smax('0, smax(smin(one, rr <<< 1), smin(two, rr)));
                MODE_MC: begin
                    t = (one + rr > 0) ? ((one + rr) >>> 1) : '0;
                    t = smax('0, smin(t, smin(two, rr <<< 1)));
                end
                MODE_BW:       t = rr;
                default:       t = '0;
            endcase
            theta = clamp_f(t);
        end
    endfunction

    function automatic logic [WORD_W-1:0] scale(input logic [WORD_W-1:0] w,
                                                input logic [FACTOR_W-1:0] f);
        logic signed [PW-1:0] p, mag, s;
        begin
            p   = $signed(w) * $signed({1'b0, f});
            mag = (p < 0) ? -p : p;
            mag = mag >>> FRAC_BITS;
            s   = (p < 0) ? -mag : mag;
            if (s > PW'(32'sh7fffffff))       scale = 32'h7fffffff;
            else if (s < -PW'(32'sh7fffffff)) scale = 32'h80000000;
            else                              scale = s[WORD_W-1:0];
        end
    endfunction

    assign mag_a     = head_job.sel_dot[DOT_W-1] ? DOT_W'(-head_job.sel_dot)
                                                 : DOT_W'(head_job.sel_dot);
    assign norm_pos  = head_job.norm > 0;
    assign ratio_sat = CMP_W'(mag_a) >=
                       (CMP_W'(unsigned'(head_job.norm)) << (QUO_W - FRAC_BITS));
    assign pop       = (state_reg == B_IDLE) && !q_stat.empty;
    assign vl_go     = (mode == MODE_VANLEER) && (r_reg > 0);
    assign out_load  = (state_reg == B_SCALE) && (!out_valid_reg || out_ready);

    assign div_start = (pop && norm_pos && !ratio_sat) || (state_reg == B_LIM && vl_go);

    always_comb begin
        if (state_reg == B_LIM) begin
            div_num = NUM_W'(r_reg[WORD_W-1:0]) << (FRAC_BITS + 1);
            div_den = DOT_W'(r_reg[WORD_W-1:0]) + (DOT_W'(1) << FRAC_BITS);
        end else begin
            div_num = NUM_W'(mag_a) << FRAC_BITS;
            div_den = unsigned'(head_job.norm);
        end
    end

    wfl_div #(.NUM_W(NUM_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (pop) begin
                    if (!norm_pos)      state_next = B_SCALE;
                    else if (ratio_sat) state_next = B_LIM;
                    else                state_next = B_DIV_R;
                end
            end
            B_DIV_R: if (div_done) state_next = B_LIM;
            B_LIM:   state_next = vl_go ? B_DIV_V : B_SCALE;
            B_DIV_V: if (div_done) state_next = B_SCALE;
            B_SCALE: if (out_load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            wave_reg   <= head_job.wave;
            neg_reg    <= head_job.sel_dot[DOT_W-1];
            scaled_reg <= norm_pos;
            f_reg      <= '0;
            r_reg      <= head_job.sel_dot[DOT_W-1] ? -RW'({1'b0, {QUO_W{1'b1}}})
                                                    : RW'({1'b0, {QUO_W{1'b1}}});
        end
        if (state_reg == B_DIV_R && div_done) begin
            r_reg <= neg_reg ? -$signed(RW'(div_quo)) : $signed(RW'(div_quo));
        end
        if (state_reg == B_LIM && !vl_go) f_reg <= theta(mode, r_reg);
        if (state_reg == B_DIV_V && div_done) f_reg <= clamp_f(TW'(div_quo));
        if (out_load) begin
            for (int j = 0; j < LANES; j++) begin
                lim_reg[j] <= scaled_reg ? scale(wave_reg[j], f_reg) : wave_reg[j];
            end
            factor_reg     <= f_reg;
            out_scaled_reg <= scaled_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load)       out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_lim    = lim_reg;
    assign out_factor = factor_reg;
    assign out_scaled = out_scaled_reg;

endmodule

/* design/wave_flux_limiter.sv */
// top level of the wave flux limiter: config registers, front, queue, back
// depends on wfl_pkg, wfl_front, wfl_queue, wfl_back (and wfl_div below it)
//
// usage:
// - s_ channel takes one edge wave per word: five q16.16 components and the
//   wave speed in s_tdata, slice start flag in s_tuser, slice end on s_tlast
// - a slice is a start word (left context), inner words, an end word (right
//   context); each inner wave comes out on m_ one word later, context never
// - m_ channel gives five limited components and the factor in m_tdata and
//   the scaled flag in m_tuser
// - cfg port: cfg_we writes cfg_wdata into register cfg_index (0 limiter
//   mode, 1 component count) at the clock edge; the user must write only while idle, the block does not enforce it
// - front: takes a word, then computes the dot products one component lane
//   per cycle through a shared multiply pair
// - back: a divider for the ratio, a second division for van leer, then
//   limiter and scaling, one inner wave at a time; a saturated ratio skips the
//   ratio division and a zero norm goes straight to scaling
// - a two-entry queue separates front and back, so input keeps flowing while
//   a result waits; a stalled m_tready holds the output register and then the
//   back, and the queue fills before s_tready drops
// - reset (aresetn low, synchronous) empties the pipeline, clears slice state
//   and loads limiter mode monotonized centred and five components
module wave_flux_limiter #(
    parameter int MAX_COMPONENTS = wfl_pkg::MAX_COMPONENTS_DEF,
    parameter int FRAC_BITS      = wfl_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // config
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [2:0]                 cfg_wdata,
    // input words
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [wfl_pkg::IN_W-1:0]   s_tdata,   // comp0..comp4, wave_speed
    input  logic                       s_tuser,   // slice_start
    input  logic                       s_tlast,   // slice_end
    // result words
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [wfl_pkg::OUT_W-1:0]  m_tdata,   // lim0..lim4, factor, zero fill
    output logic                       m_tuser    // was_scaled
);
    import wfl_pkg::*;

    localparam int FAC_LO = LANES * WORD_W;

    mode_t                        mode_reg;
    logic [CNT_W-1:0]             comps_reg;
    logic [CNT_W-1:0]             n_active;
    logic [LANES-1:0][WORD_W-1:0] in_wave;
    logic                         q_push, q_pop;
    job_t                         push_job, head_job;
    q_status_t                    q_stat;
    logic [LANES-1:0][WORD_W-1:0] out_lim;
    logic [FACTOR_W-1:0]          out_factor;

    // config registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_MC;
            comps_reg <= CNT_W'(LANES);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_wdata;
                CFG_COMPS: comps_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // active lane count is the smallest of the setting, the build limit, the lanes
    always_comb begin
        n_active = comps_reg;
        if (int'(n_active) > MAX_COMPONENTS) n_active = CNT_W'(MAX_COMPONENTS);
        if (int'(n_active) > LANES)          n_active = CNT_W'(LANES);
    end

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            in_wave[j] = s_tdata[j*WORD_W +: WORD_W];
        end
    end

    wfl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_wave  (in_wave),
        .in_speed (s_tdata[LANES*WORD_W +: WORD_W]),
        .in_start (s_tuser),
        .in_end   (s_tlast),
        .n_active (n_active),
        .q_stat   (q_stat),
        .push     (q_push),
        .push_job (push_job)
    );

    wfl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_stat)
    );

    wfl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .head_job   (head_job),
        .pop        (q_pop),
        .mode       (mode_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_lim    (out_lim),
        .out_factor (out_factor),
        .out_scaled (m_tuser)
    );

    assign m_tdata = {{(OUT_W - FAC_LO - FACTOR_W){1'b0}}, out_factor, out_lim};

    // an unscaled wave always reports a zero factor
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[FAC_LO +: FACTOR_W] == '0)
        else $error("unscaled result with nonzero factor");

    // the front never writes a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    // the back never reads an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // a queue push without a pop in the same cycle is followed by a queue that is not empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && !q_pop |=> !q_stat.empty)
        else $error("queue lost a job");

endmodule
